FILE: sv/decimal_fixed_point_alu_core_defines.svh
// Assertion macros shared by the decimal fixed-point ALU.
`ifndef DECIMAL_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define DECIMAL_FIXED_POINT_ALU_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decimal ALU check failed");

// Next-cycle implication, checked outside reset.
`define DFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decimal ALU check failed");

`endif

FILE: sv/dfpa_pkg.sv
// Shared codes, widths and the power-of-ten table of the decimal ALU.
package dfpa_pkg;

  localparam int SCALE_DIGITS_DEF = 10;
  localparam int MAX_DIGITS       = 18;
  localparam int RAW_W            = 128;
  localparam int WIDE_W           = 256;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_RND = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVF     = 2'd1;
  localparam logic [1:0] ST_DIV0    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic CFG_LIMIT_HIGH = 1'b0;
  localparam logic CFG_LIMIT_LOW  = 1'b1;

  localparam logic [63:0] POW10 [0:MAX_DIGITS] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000,
    64'd100000000000, 64'd1000000000000, 64'd10000000000000,
    64'd100000000000000, 64'd1000000000000000, 64'd10000000000000000,
    64'd100000000000000000, 64'd1000000000000000000
  };

endpackage

FILE: sv/dfpa_mul_cell.sv
// One shift-add step of a multiplier chain, multiplier bits taken MSB first.
module dfpa_mul_cell #(
  parameter int ACC_W  = 256,
  parameter int MC_W   = 129,
  parameter int MP_W   = 128,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ACC_W-1:0]  acc_i,
  input  logic [MC_W-1:0]   mcand_i,
  input  logic [MP_W-1:0]   mplier_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ACC_W-1:0]  acc_o,
  output logic [MC_W-1:0]   mcand_o,
  output logic [MP_W-1:0]   mplier_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [ACC_W-1:0] acc_d;

  // Double the partial product and add the multiplicand for a set bit.
  assign acc_d = {acc_i[ACC_W-2:0], 1'b0} +
                 (mplier_i[MP_W-1] ? ACC_W'(mcand_i) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_o    <= acc_d;
      mcand_o  <= mcand_i;
      mplier_o <= {mplier_i[MP_W-2:0], 1'b0};
      side_o   <= side_i;
    end
  end

endmodule

FILE: sv/dfpa_div_cell.sv
// One restoring long-division step: shift in a dividend bit, trial subtract.
module dfpa_div_cell #(
  parameter int NQ_W   = 256,
  parameter int D_W    = 128,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NQ_W-1:0]   nq_i,
  input  logic [D_W-1:0]    rem_i,
  input  logic [D_W-1:0]    div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NQ_W-1:0]   nq_o,
  output logic [D_W-1:0]    rem_o,
  output logic [D_W-1:0]    div_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [D_W-1:0] trial;
  logic           ge;

  // Remainder stays below the divisor, which is at most 2^(D_W-1).
  assign trial = {rem_i[D_W-2:0], nq_i[NQ_W-1]};
  assign ge    = (trial >= div_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? (trial - div_i) : trial;
      nq_o   <= {nq_i[NQ_W-2:0], ge};
      div_o  <= div_i;
      side_o <= side_i;
    end
  end

endmodule

FILE: sv/decimal_fixed_point_alu_core.sv
// Decimal fixed-point ALU: top level with front end, cell chains and output skid.
// Stages: capture, sign split, 128 multiplier cells, 256 division cells, rounding,
//   FW rescale cells (FW being the bit width of 10^SCALE_DIGITS), final stage.
// Throughput: one request per cycle while the skid entry is empty; the whole chain
//   advances together and stalls while the skid entry holds a result.
// Reset: asynchronous, active low; clears valid flags and sets the limit to 2^127-1.
`include "decimal_fixed_point_alu_core_defines.svh"

module decimal_fixed_point_alu_core #(
  parameter int SCALE_DIGITS = dfpa_pkg::SCALE_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [63:0] a_high_i,
  input  logic [63:0]        a_low_i,
  input  logic signed [63:0] b_high_i,
  input  logic [63:0]        b_low_i,
  input  logic [3:0]         round_digits_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] result_high_o,
  output logic [63:0]        result_low_o,
  output logic [1:0]         status_o
);

  localparam int RW  = dfpa_pkg::RAW_W;
  localparam int WW  = dfpa_pkg::WIDE_W;
  // Width of the rescale factor, set by the largest power of ten in use.
  localparam int FW  = $clog2(dfpa_pkg::POW10[SCALE_DIGITS] + 64'd1);
  localparam int MSW = 1 + 2 + RW + FW;   // neg, status, divisor, factor
  localparam int DSW = 1 + 2 + FW;        // neg, status, factor
  localparam int RSW = 1 + 2;             // neg, status
  localparam logic [RW-1:0] SCALE_P = RW'(dfpa_pkg::POW10[SCALE_DIGITS]);

  // Limit registers; user writes only while the block is idle; not enforced here.
  logic [62:0] limit_high_q;
  logic [63:0] limit_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_high_q <= '1;
      limit_low_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dfpa_pkg::CFG_LIMIT_HIGH: limit_high_q <= cfg_data_i[62:0];
        dfpa_pkg::CFG_LIMIT_LOW:  limit_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the whole chain unless the skid stage is holding a result.
  logic en;
  logic skid_valid_q;
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // Stage 0: capture the request.
  logic          s0_valid_q;
  logic [2:0]    s0_mode_q;
  logic [RW-1:0] s0_a_q, s0_b_q;
  logic [3:0]    s0_dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mode_q <= mode_i;
      s0_a_q    <= {a_high_i, a_low_i};
      s0_b_q    <= {b_high_i, b_low_i};
      s0_dig_q  <= round_digits_i;
    end
  end

  // Stage 1: split into sign and magnitude.
  logic          s1_valid_q;
  logic [2:0]    s1_mode_q;
  logic [3:0]    s1_dig_q;
  logic          s1_na_q, s1_nb_q;
  logic [RW-1:0] s1_ma_q, s1_mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q <= s0_mode_q;
      s1_dig_q  <= s0_dig_q;
      s1_na_q   <= s0_a_q[RW-1];
      s1_nb_q   <= s0_b_q[RW-1];
      s1_ma_q   <= s0_a_q[RW-1] ? (RW'(0) - s0_a_q) : s0_a_q;
      s1_mb_q   <= s0_b_q[RW-1] ? (RW'(0) - s0_b_q) : s0_b_q;
    end
  end

  // Stage 2: every mode becomes round_half_even(mcand * mplier / divisor) * factor.
  // Add and subtract form their magnitude here and pass through with unit terms.
  logic          sb, same_sign, mag_ge, dig_ok;
  logic [RW:0]   sum_mag;
  logic [RW-1:0] diff_mag;
  logic [4:0]    pow_idx;
  logic [FW-1:0] rnd_f;
  logic          s2_neg;
  logic [1:0]    s2_st;
  logic [RW:0]   s2_mcand;
  logic [RW-1:0] s2_mplier, s2_div;
  logic [FW-1:0] s2_f;

  assign sb        = (s1_mode_q == dfpa_pkg::MODE_SUB) ? !s1_nb_q : s1_nb_q;
  assign same_sign = (s1_na_q == sb);
  assign mag_ge    = (s1_ma_q >= s1_mb_q);
  assign sum_mag   = {1'b0, s1_ma_q} + {1'b0, s1_mb_q};
  assign diff_mag  = mag_ge ? (s1_ma_q - s1_mb_q) : (s1_mb_q - s1_ma_q);
  assign dig_ok    = ({1'b0, s1_dig_q} <= 5'(SCALE_DIGITS));
  assign pow_idx   = dig_ok ? (5'(SCALE_DIGITS) - {1'b0, s1_dig_q}) : 5'd0;
  assign rnd_f     = FW'(dfpa_pkg::POW10[pow_idx]);

  always_comb begin
    s2_neg    = 1'b0;
    s2_st     = dfpa_pkg::ST_OK;
    s2_mcand  = {1'b0, s1_ma_q};
    s2_mplier = RW'(1);
    s2_div    = RW'(1);
    s2_f      = FW'(1);
    unique case (s1_mode_q) inside
      dfpa_pkg::MODE_ADD, dfpa_pkg::MODE_SUB: begin
        s2_mcand = same_sign ? sum_mag : {1'b0, diff_mag};
        s2_neg   = (same_sign || mag_ge) ? s1_na_q : sb;
      end
      dfpa_pkg::MODE_MUL: begin
        s2_mplier = s1_mb_q;
        s2_div    = SCALE_P;
        s2_neg    = s1_na_q ^ s1_nb_q;
      end
      dfpa_pkg::MODE_DIV: begin
        s2_mplier = SCALE_P;
        s2_neg    = s1_na_q ^ s1_nb_q;
        if (s1_mb_q == '0) begin
          s2_st = dfpa_pkg::ST_DIV0;
        end else begin
          s2_div = s1_mb_q;
        end
      end
      dfpa_pkg::MODE_RND: begin
        s2_neg = s1_na_q;
        if (!dig_ok) begin
          s2_st = dfpa_pkg::ST_INVALID;
        end else begin
          s2_div = RW'(rnd_f);
          s2_f   = rnd_f;
        end
      end
      default: s2_st = dfpa_pkg::ST_INVALID;
    endcase
  end

  // Multiplier chain: one cell per multiplier bit.
  logic          m_valid  [0:RW];
  logic [WW-1:0] m_acc    [0:RW];
  logic [RW:0]   m_mcand  [0:RW];
  logic [RW-1:0] m_mplier [0:RW];
  logic [MSW-1:0] m_side  [0:RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid[0] <= 1'b0;
    end else if (en) begin
      m_valid[0] <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_acc[0]    <= '0;
      m_mcand[0]  <= s2_mcand;
      m_mplier[0] <= s2_mplier;
      m_side[0]   <= {s2_neg, s2_st, s2_div, s2_f};
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_mul
    dfpa_mul_cell #(
      .ACC_W (WW),
      .MC_W  (RW + 1),
      .MP_W  (RW),
      .SIDE_W(MSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (m_valid[i]),
      .acc_i   (m_acc[i]),
      .mcand_i (m_mcand[i]),
      .mplier_i(m_mplier[i]),
      .side_i  (m_side[i]),
      .valid_o (m_valid[i+1]),
      .acc_o   (m_acc[i+1]),
      .mcand_o (m_mcand[i+1]),
      .mplier_o(m_mplier[i+1]),
      .side_o  (m_side[i+1])
    );
  end

  // Division chain: one cell per numerator bit, quotient shifts in behind it.
  logic           d_valid [0:WW];
  logic [WW-1:0]  d_nq    [0:WW];
  logic [RW-1:0]  d_rem   [0:WW];
  logic [RW-1:0]  d_div   [0:WW];
  logic [DSW-1:0] d_side  [0:WW];
  logic [MSW-1:0] m_last;

  assign m_last    = m_side[RW];
  assign d_valid[0] = m_valid[RW];
  assign d_nq[0]    = m_acc[RW];
  assign d_rem[0]   = '0;
  assign d_div[0]   = m_last[FW +: RW];
  assign d_side[0]  = {m_last[MSW-1 -: 3], m_last[FW-1:0]};

  for (genvar i = 0; i < WW; i++) begin : g_div
    dfpa_div_cell #(
      .NQ_W  (WW),
      .D_W   (RW),
      .SIDE_W(DSW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(d_valid[i]),
      .nq_i   (d_nq[i]),
      .rem_i  (d_rem[i]),
      .div_i  (d_div[i]),
      .side_i (d_side[i]),
      .valid_o(d_valid[i+1]),
      .nq_o   (d_nq[i+1]),
      .rem_o  (d_rem[i+1]),
      .div_o  (d_div[i+1]),
      .side_o (d_side[i+1])
    );
  end

  // Round half to even on the final remainder.
  logic [RW:0]    twice_rem;
  logic           round_incr;
  logic           r_valid_q;
  logic [WW-1:0]  r_q_q;
  logic [DSW-1:0] r_side_q;

  assign twice_rem  = {d_rem[WW], 1'b0};
  assign round_incr = (twice_rem > {1'b0, d_div[WW]}) ||
                      ((twice_rem == {1'b0, d_div[WW]}) && d_nq[WW][0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= d_valid[WW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q_q    <= d_nq[WW] + WW'(round_incr);
      r_side_q <= d_side[WW];
    end
  end

  // Rescale chain: multiply the rounded quotient back by the factor.
  logic           s_valid  [0:FW];
  logic [WW-1:0]  s_acc    [0:FW];
  logic [WW-1:0]  s_mcand  [0:FW];
  logic [FW-1:0]  s_mplier [0:FW];
  logic [RSW-1:0] s_side   [0:FW];

  assign s_valid[0]  = r_valid_q;
  assign s_acc[0]    = '0;
  assign s_mcand[0]  = r_q_q;
  assign s_mplier[0] = r_side_q[FW-1:0];
  assign s_side[0]   = r_side_q[DSW-1 -: RSW];

  for (genvar i = 0; i < FW; i++) begin : g_scale
    dfpa_mul_cell #(
      .ACC_W (WW),
      .MC_W  (WW),
      .MP_W  (FW),
      .SIDE_W(RSW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s_valid[i]),
      .acc_i   (s_acc[i]),
      .mcand_i (s_mcand[i]),
      .mplier_i(s_mplier[i]),
      .side_i  (s_side[i]),
      .valid_o (s_valid[i+1]),
      .acc_o   (s_acc[i+1]),
      .mcand_o (s_mcand[i+1]),
      .mplier_o(s_mplier[i+1]),
      .side_o  (s_side[i+1])
    );
  end

  // Final stage: limit check, sign, and zero on any error.
  logic [WW-1:0]  mag;
  logic [RSW-1:0] s_last;
  logic           over;
  logic [1:0]     f_st;
  logic           f_valid_q;
  logic [RW-1:0]  f_res_q;
  logic [1:0]     f_st_q;

  assign mag    = s_acc[FW];
  assign s_last = s_side[FW];
  assign over   = (mag[WW-1:RW] != '0) ||
                  (mag[RW-1:0] > {1'b0, limit_high_q, limit_low_q});
  assign f_st   = (s_last[1:0] != dfpa_pkg::ST_OK) ? s_last[1:0] :
                  over ? dfpa_pkg::ST_OVF : dfpa_pkg::ST_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= s_valid[FW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_st_q  <= f_st;
      f_res_q <= (f_st != dfpa_pkg::ST_OK) ? '0 :
                 s_last[2] ? (RW'(0) - mag[RW-1:0]) : mag[RW-1:0];
    end
  end

  // Output register with a skid entry behind it.
  logic          out_valid_q;
  logic [RW-1:0] out_res_q, skid_res_q;
  logic [1:0]    out_st_q, skid_st_q;
  logic          take_new;

  assign take_new = en && f_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q  <= skid_valid_q || take_new;
      skid_valid_q <= 1'b0;
    end else if (take_new) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_res_q <= skid_valid_q ? skid_res_q : f_res_q;
      out_st_q  <= skid_valid_q ? skid_st_q : f_st_q;
    end else if (take_new) begin
      skid_res_q <= f_res_q;
      skid_st_q  <= f_st_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = out_res_q[RW-1:64];
  assign result_low_o  = out_res_q[63:0];
  assign status_o      = out_st_q;

  `DFPA_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `DFPA_ASSERT_NOW(a_error_zero, clk_i, rst_ni, out_valid_q && (out_st_q != dfpa_pkg::ST_OK), out_res_q == '0)
  `DFPA_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && out_ready_i, out_valid_q && !skid_valid_q)

endmodule

FILE: verif/dfpa_result_checker.sv
// Checker for the decimal ALU: predicts each result and compares it on arrival.
module dfpa_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         mode_i,
  input  logic [63:0]        a_high_i,
  input  logic [63:0]        a_low_i,
  input  logic [63:0]        b_high_i,
  input  logic [63:0]        b_low_i,
  input  logic [3:0]         round_digits_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [63:0]        result_high_i,
  input  logic [63:0]        result_low_i,
  input  logic [1:0]         status_i,
  output int                 mismatch_count_o,
  output int                 awaited_count_o
);

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic [1:0]  status;
  } dec_result_t;

  logic [62:0]  limit_high_q;
  logic [63:0]  limit_low_q;
  dec_result_t  awaited_results [$];
  int           mismatches;

  // Half-even quotient of n / d.
  function automatic logic [255:0] div_half_even(logic [255:0] n, logic [127:0] d);
    logic [255:0] q;
    logic [255:0] r;
    logic [128:0] twice;
    q     = n / {128'd0, d};
    r     = n % {128'd0, d};
    twice = {r[127:0], 1'b0};
    if (twice > {1'b0, d} || (twice == {1'b0, d} && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic dec_result_t decimal_outcome(logic [2:0] mode, logic [127:0] a,
                                                  logic [127:0] b, logic [3:0] digits);
    logic [127:0] ma, mb, lim, f, rounded;
    logic [256:0] mag;
    logic [127:0] raw;
    logic [1:0]   st;
    logic         na, nb, sb, neg;
    logic [63:0]  scale;
    dec_result_t  res;
    scale = dfpa_pkg::POW10[dfpa_pkg::SCALE_DIGITS_DEF];
    lim = {1'b0, limit_high_q, limit_low_q};
    na  = a[127];
    nb  = b[127];
    ma  = na ? -a : a;
    mb  = nb ? -b : b;
    mag = '0;
    neg = 1'b0;
    st  = dfpa_pkg::ST_OK;
    case (mode) inside
      dfpa_pkg::MODE_ADD, dfpa_pkg::MODE_SUB: begin
        sb = (mode == dfpa_pkg::MODE_SUB) ? !nb : nb;
        if (na == sb) begin
          mag = {129'd0, ma} + {129'd0, mb};
          neg = na;
        end else if (ma >= mb) begin
          mag = {129'd0, ma - mb};
          neg = na;
        end else begin
          mag = {129'd0, mb - ma};
          neg = sb;
        end
      end
      dfpa_pkg::MODE_MUL: begin
        mag = {1'b0, div_half_even({128'd0, ma} * {128'd0, mb}, {64'd0, scale})};
        neg = na != nb;
      end
      dfpa_pkg::MODE_DIV: begin
        if (mb == 0) st = dfpa_pkg::ST_DIV0;
        else begin
          mag = {1'b0, div_half_even({128'd0, ma} * {192'd0, scale}, mb)};
          neg = na != nb;
        end
      end
      dfpa_pkg::MODE_RND: begin
        if (int'(digits) > dfpa_pkg::SCALE_DIGITS_DEF) st = dfpa_pkg::ST_INVALID;
        else begin
          f       = {64'd0, dfpa_pkg::POW10[dfpa_pkg::SCALE_DIGITS_DEF - int'(digits)]};
          rounded = 128'(div_half_even({128'd0, ma}, f));
          mag     = {1'b0, {128'd0, rounded} * {128'd0, f}};
          neg     = na;
        end
      end
      default: st = dfpa_pkg::ST_INVALID;
    endcase
    if (st == dfpa_pkg::ST_OK && (mag[256:128] != 0 || mag[127:0] > lim)) st = dfpa_pkg::ST_OVF;
    raw = (st != dfpa_pkg::ST_OK) ? 128'd0 : (neg ? -mag[127:0] : mag[127:0]);
    res.high   = raw[127:64];
    res.low    = raw[63:0];
    res.status = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dec_result_t want;
    if (!rst_ni) begin
      limit_high_q <= '1;
      limit_low_q  <= '1;
      mismatches   = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == dfpa_pkg::CFG_LIMIT_HIGH) limit_high_q <= cfg_data_i[62:0];
        else limit_low_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_i)
        awaited_results = {awaited_results,
                           decimal_outcome(mode_i, {a_high_i, a_low_i},
                                           {b_high_i, b_low_i}, round_digits_i)};
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result %h_%h status %0d", $time,
                   result_high_i, result_low_i, status_i);
        end else begin
          want = awaited_results.pop_front();
          if (result_high_i !== want.high) begin
            mismatches++;
            $display("%0t result_high expected %h actual %h", $time, want.high,
                     result_high_i);
          end
          if (result_low_i !== want.low) begin
            mismatches++;
            $display("%0t result_low expected %h actual %h", $time, want.low,
                     result_low_i);
          end
          if (status_i !== want.status) begin
            mismatches++;
            $display("%0t status expected %0d actual %0d", $time, want.status, status_i);
          end
        end
      end
    end
  end

  assign mismatch_count_o = mismatches;
  assign awaited_count_o  = awaited_results.size();

endmodule

FILE: verif/tb.sv
// Testbench top: drives requests and limit writes into the decimal ALU and gives the verdict.
module tb;

  // Unused mode codes; the block must flag them as invalid.
  localparam logic [2:0] MODE_RSV5 = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;
  localparam logic [2:0] MODE_RSV7 = 3'd7;

  localparam int LATENCY     = 424;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 380;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode_i = dfpa_pkg::MODE_ADD;
  logic signed [63:0] a_high_i = '0;
  logic [63:0]        a_low_i = '0;
  logic signed [63:0] b_high_i = '0;
  logic [63:0]        b_low_i = '0;
  logic [3:0]         round_digits_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] result_high_o;
  logic [63:0]        result_low_o;
  logic [1:0]         status_o;

  int mismatch_count;
  int awaited_count;
  int cycle_count = 0;
  int sent_in_burst = 0;
  bit send_busy_stretch = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_fixed_point_alu_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .a_high_i, .a_low_i, .b_high_i, .b_low_i,
    .round_digits_i, .out_valid_o, .out_ready_i, .result_high_o, .result_low_o, .status_o
  );

  dfpa_result_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i,
    .a_high_i, .a_low_i, .b_high_i, .b_low_i, .round_digits_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .result_high_i(result_high_o), .result_low_i(result_low_o), .status_i(status_o),
    .mismatch_count_o(mismatch_count), .awaited_count_o(awaited_count)
  );

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: hold ready low for a random stall before each result, with stretches
  // of 30 results where ready simply stays high.
  initial begin
    int stall;
    int stretch_left;
    stretch_left = 0;
    @(posedge rst_ni);
    forever begin
      if (stretch_left > 0) begin
        stall = 0;
        stretch_left--;
      end else begin
        stall = $urandom_range(0, 16);
        if ($urandom_range(0, 40) == 0) stretch_left = 30;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Send one request; return at the edge that accepts it, valid still high so that
  // back-to-back requests never drop valid in between.
  task automatic send_request(logic [2:0] mode, logic [127:0] a, logic [127:0] b,
                              logic [3:0] digits);
    int gap;
    if (sent_in_burst == 0) begin
      send_busy_stretch = ($urandom_range(0, 3) == 0);
      sent_in_burst = 40;
    end
    sent_in_burst--;
    gap = send_busy_stretch ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    a_high_i       <= a[127:64];
    a_low_i        <= a[63:0];
    b_high_i       <= b[127:64];
    b_low_i        <= b[63:0];
    round_digits_i <= digits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drain the pipeline, then program both halves of the limit.
  task automatic set_limit(logic [127:0] lim);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dfpa_pkg::CFG_LIMIT_HIGH;
    cfg_data_i  <= lim[127:64];
    @(posedge clk_i);
    cfg_index_i <= dfpa_pkg::CFG_LIMIT_LOW;
    cfg_data_i  <= lim[63:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Raw operand drawn from a mix: zero, edge values, scaled-ish small numbers,
  // full-width noise and values sitting exactly on a rounding tie.
  function automatic logic [127:0] pick_raw();
    logic [127:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 6))
          0: v = 128'd1;
          1: v = '1;
          2: v = {1'b0, {127{1'b1}}};
          3: v = {1'b1, 127'd0};
          4: v = {64'd0, dfpa_pkg::POW10[10]};
          5: v = -{64'd0, dfpa_pkg::POW10[10]};
          default: v = {1'b1, 126'd0, 1'b1};
        endcase
      end
      2, 3, 4: v = {64'd0, $urandom, $urandom} >> $urandom_range(0, 40);
      5, 6: v = {$urandom, $urandom, $urandom, $urandom};
      default:
        v = 128'($urandom_range(0, 999)) * dfpa_pkg::POW10[10] +
            128'(5) * dfpa_pkg::POW10[$urandom_range(0, 9)];
    endcase
    if ($urandom_range(0, 1) && v[127] == 1'b0) v = -v;
    return v;
  endfunction

  task automatic send_random_batch(int count);
    logic [2:0] mode;
    repeat (count) begin
      mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      send_request(mode, pick_raw(), pick_raw(), 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    logic [127:0] max_raw;
    logic [127:0] min_raw;
    logic [127:0] one_unit;
    max_raw  = {1'b0, {127{1'b1}}};
    min_raw  = {1'b1, 127'd0};
    one_unit = {64'd0, dfpa_pkg::POW10[10]};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: carry out of the add, the most negative subtrahend, zero operands,
    // half-even ties, zero divisor, bad digit counts and unused modes.
    send_request(dfpa_pkg::MODE_ADD, max_raw, max_raw, 4'd0);
    send_request(dfpa_pkg::MODE_ADD, min_raw, min_raw, 4'd0);
    send_request(dfpa_pkg::MODE_SUB, 128'd0, min_raw, 4'd0);
    send_request(dfpa_pkg::MODE_SUB, -128'd1, min_raw, 4'd0);
    send_request(dfpa_pkg::MODE_SUB, one_unit, max_raw, 4'd15);
    send_request(dfpa_pkg::MODE_MUL, 128'd0, max_raw, 4'd0);
    send_request(dfpa_pkg::MODE_MUL, 128'd1, 128'd5000000000, 4'd0);
    send_request(dfpa_pkg::MODE_MUL, 128'd3, 128'd5000000000, 4'd0);
    send_request(dfpa_pkg::MODE_MUL, -128'd3, 128'd5000000000, 4'd0);
    send_request(dfpa_pkg::MODE_MUL, max_raw, max_raw, 4'd0);
    send_request(dfpa_pkg::MODE_MUL, min_raw, one_unit, 4'd0);
    send_request(dfpa_pkg::MODE_DIV, one_unit, 128'd0, 4'd0);
    send_request(dfpa_pkg::MODE_DIV, 128'd0, one_unit, 4'd0);
    send_request(dfpa_pkg::MODE_DIV, one_unit, 128'd3 * one_unit, 4'd0);
    send_request(dfpa_pkg::MODE_DIV, max_raw, min_raw, 4'd0);
    send_request(dfpa_pkg::MODE_DIV, 128'd1, max_raw, 4'd0);
    send_request(dfpa_pkg::MODE_RND, 128'd25 * one_unit / 10, 128'd0, 4'd0);
    send_request(dfpa_pkg::MODE_RND, -(128'd35 * one_unit / 10), 128'd0, 4'd0);
    send_request(dfpa_pkg::MODE_RND, max_raw, 128'd0, 4'd10);
    send_request(dfpa_pkg::MODE_RND, min_raw, 128'd0, 4'd0);
    send_request(dfpa_pkg::MODE_RND, one_unit, 128'd0, 4'd11);
    send_request(dfpa_pkg::MODE_RND, one_unit, 128'd0, 4'd15);
    send_request(MODE_RSV5, one_unit, one_unit, 4'd0);
    send_request(MODE_RSV6, max_raw, min_raw, 4'd3);
    send_request(MODE_RSV7, '1, '1, 4'd15);
    send_random_batch(PHASE_ITEMS);

    // Limit of zero: only zero results pass.
    set_limit(128'd0);
    send_request(dfpa_pkg::MODE_RND, max_raw, 128'd0, 4'd10);
    send_request(dfpa_pkg::MODE_SUB, one_unit, one_unit, 4'd0);
    send_random_batch(PHASE_ITEMS);

    // Moderate limit, ten integer digits.
    set_limit(128'd100000000000000000000);
    send_random_batch(PHASE_ITEMS);

    // Random limit with both halves populated.
    set_limit({1'b0, $urandom, $urandom, $urandom, 31'($urandom)});
    send_random_batch(PHASE_ITEMS);

    // Back to the widest limit.
    set_limit(max_raw);
    send_random_batch(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_count != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
